FILE: rtl/md5_pkg.sv
`default_nettype none
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } md5_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_EMIT
  } md5_state_t;

  typedef struct packed {
    logic       load_byte;
    logic       put_pad;
    logic       put_len;
    logic       start;
    logic       init;
    logic [1:0] emit_sel;
  } md5_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       last_slot;
    logic       pad_spill;
  } md5_sts_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LAST_FIT_POS = 6'd55;
  localparam logic [5:0]  LAST_SLOT = 6'd63;
  localparam int          CNT_W = 61;

  function automatic logic [31:0] round_add(input logic [5:0] s);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    return k[s];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] s);
    logic [4:0] r [16];
    r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return r[{s[5:4], s[1:0]}];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/md5_datapath.sv
`default_nettype none
module md5_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      byte_in,
  input  wire md5_pkg::md5_cmd_t cmd,
  output md5_pkg::md5_sts_t    sts,
  output logic [31:0]          word_out
);
  import md5_pkg::*;

  logic [31:0]      buf_r [16];
  logic [31:0]      chain_r [4];
  logic [31:0]      a_r, b_r, c_r, d_r;
  logic [CNT_W-1:0] cnt_r;
  logic [5:0]       step_r;
  logic             run_r;

  logic [5:0]  pos;
  logic [3:0]  widx;
  logic [31:0] f, t, rot;
  logic [4:0]  sh;
  logic [63:0] bits;

  assign pos  = cnt_r[5:0];
  assign bits = {cnt_r, 3'b000};

  always_comb begin
    unique case (step_r[5:4])
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        widx = step_r[3:0];
      end
      2'd1: begin
        f = (b_r & d_r) | (c_r & ~d_r);
        widx = 4'(5 * step_r[3:0] + 1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        widx = 4'(3 * step_r[3:0] + 5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        widx = 4'(7 * step_r[3:0]);
      end
    endcase
    t   = a_r + f + buf_r[widx] + round_add(step_r);
    sh  = rot_amount(step_r);
    rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  assign sts.busy       = run_r;
  // the next byte completes the block
  assign sts.last_slot  = pos == LAST_SLOT;
  assign sts.pad_spill  = pos > LAST_FIT_POS;
  assign word_out       = chain_r[cmd.emit_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      step_r  <= '0;
      cnt_r   <= '0;
      chain_r <= '{IV_A, IV_B, IV_C, IV_D};
      for (int i = 0; i < 16; i++) buf_r[i] <= '0;
    end else begin
      if (cmd.init) begin
        cnt_r   <= '0;
        chain_r <= '{IV_A, IV_B, IV_C, IV_D};
      end
      if (cmd.load_byte) begin
        buf_r[pos[5:2]][8*pos[1:0] +: 8] <= byte_in;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.put_pad) buf_r[pos[5:2]][8*pos[1:0] +: 8] <= PAD_BYTE;
      if (cmd.put_len) begin
        buf_r[14] <= bits[31:0];
        buf_r[15] <= bits[63:32];
      end
      if (cmd.start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        a_r <= chain_r[0];
        b_r <= chain_r[1];
        c_r <= chain_r[2];
        d_r <= chain_r[3];
      end else if (run_r) begin
        a_r <= d_r;
        d_r <= c_r;
        c_r <= b_r;
        b_r <= b_r + rot;
        step_r <= step_r + 1'b1;
        if (step_r == 6'd63) begin
          run_r <= 1'b0;
          chain_r[0] <= chain_r[0] + d_r;
          chain_r[1] <= chain_r[1] + b_r + rot;
          chain_r[2] <= chain_r[2] + b_r;
          chain_r[3] <= chain_r[3] + c_r;
          for (int i = 0; i < 16; i++) buf_r[i] <= '0;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/md5_control.sv
`default_nettype none
module md5_control (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_byte_valid,
  input  wire logic              in_last,
  output logic                   in_stall,
  output logic                   out_valid,
  output logic                   out_last,
  input  wire logic              out_stall,
  input  wire md5_pkg::md5_sts_t sts,
  output md5_pkg::md5_cmd_t      cmd
);
  import md5_pkg::*;

  md5_state_t state_r, state_nxt;
  logic       fin_r, fin_nxt;
  logic       full_r, full_nxt;
  logic       pad_r, pad_nxt;
  logic       len_r, len_nxt;
  logic [1:0] emit_r, emit_nxt;
  logic       acc, emit_go;

  assign acc     = in_valid && !in_stall;
  assign emit_go = out_valid && !out_stall;

  // after a full block, compress; after last, pad/length and compress, then emit
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    full_nxt  = full_r;
    pad_nxt   = pad_r;
    len_nxt   = len_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          fin_nxt  = in_last;
          full_nxt = in_byte_valid && sts.last_slot;
          pad_nxt  = 1'b0;
          len_nxt  = 1'b0;
          if (in_last || (in_byte_valid && sts.last_slot)) state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        // a filled block compresses before any padding
        priority if (full_r) begin
          full_nxt  = 1'b0;
          state_nxt = ST_COMP;
        end else if (!pad_r) begin
          pad_nxt   = 1'b1;
          len_nxt   = !sts.pad_spill;
          state_nxt = ST_COMP;
        end else begin
          len_nxt   = 1'b1;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (!sts.busy) begin
          priority if (!fin_r) state_nxt = ST_IDLE;
          else if (len_r) begin
            state_nxt = ST_EMIT;
            emit_nxt = 2'd0;
          end else state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          emit_nxt = emit_r + 1'b1;
          if (emit_r == 2'd3) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    out_last     = 1'b0;
    cmd.emit_sel = emit_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_byte = in_valid && in_byte_valid;
      end
      ST_PAD: begin
        cmd.start = 1'b1;
        if (!full_r) begin
          if (!pad_r) begin
            cmd.put_pad = 1'b1;
            cmd.put_len = !sts.pad_spill;
          end else begin
            cmd.put_len = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = emit_r == 2'd3;
        if (emit_go && emit_r == 2'd3) cmd.init = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      full_r  <= 1'b0;
      pad_r   <= 1'b0;
      len_r   <= 1'b0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      full_r  <= full_nxt;
      pad_r   <= pad_nxt;
      len_r   <= len_nxt;
      emit_r  <= emit_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/md5_message_digest.sv
// MD5 digest engine.
// Input channel: one transfer per message byte (in_data.byte_valid) with
// in_data.last marking the end of a message; last with no byte ends the
// message at the bytes taken so far (empty message allowed).
// Output channel: four transfers per message, digest words A, B, C, D,
// each to be sent lowest byte first; out_data.last_word marks D.
// Throughput: bytes that do not fill a block go back to back. A byte that
// completes a 64-byte block holds the input while the block is dispatched,
// the 64-step compression loop runs at one step per cycle, and the loop
// finishes. After a last transfer the engine pads and compresses before
// it offers the first digest word, with a second compression when the
// padding spills into a second block or the last byte fills a block; the
// four words then go one per cycle while the output is not stalled.
// Input is stalled while a compression runs or the digest is shown.
// Reset loads the standard chaining words and clears buffer and count.
// A stalled output holds its word; the engine waits without losing state.
`default_nettype none
module md5_message_digest (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire md5_pkg::md5_in_t in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output md5_pkg::md5_out_t     out_data,
  input  wire logic             out_stall
);
  import md5_pkg::*;

  md5_cmd_t    cmd;
  md5_sts_t    sts;
  logic [31:0] word;
  logic        last_w;

  md5_control u_ctrl (
    .clk, .rst_n, .in_valid,
    .in_byte_valid(in_data.byte_valid), .in_last(in_data.last), .in_stall,
    .out_valid, .out_last(last_w), .out_stall, .sts, .cmd
  );

  md5_datapath u_dp (
    .clk, .rst_n, .byte_in(in_data.data_byte), .cmd, .sts, .word_out(word)
  );

  assign out_data.digest_word = word;
  assign out_data.last_word   = last_w;
endmodule
`default_nettype wire

FILE: rtl/md5_checker.sv
`default_nettype none
module md5_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire md5_pkg::md5_in_t in_data,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire md5_pkg::md5_out_t out_data,
  input wire logic             out_stall
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during digest");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_word |=> !out_valid)
    else $error("extra word after last");
  a_end_msg: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last |=> !out_valid)
    else $error("digest without last");
endmodule

bind md5_message_digest md5_checker u_chk (.*);
`default_nettype wire

FILE: dv/md5_message_digest_tb.sv
`default_nettype none
module md5_message_digest_tb;
  import md5_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  md5_in_t  in_data;
  logic     in_stall;
  logic     out_valid;
  md5_out_t out_data;
  logic     out_stall;

  md5_message_digest i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  // digest predictor state
  logic [31:0] chain_q [4];
  logic [31:0] words_q [16];
  logic [60:0] nbytes_q;

  md5_in_t  send_q [$];
  md5_out_t digest_q [$];
  int       err_cnt;
  int       cycle_cnt;
  bit       calm;
  bit       drain_hold;
  bit       in_hold;

  function automatic logic [31:0] rnd_const(input int s);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    return k[s];
  endfunction

  task automatic digest_init();
    chain_q[0] = IV_A;
    chain_q[1] = IV_B;
    chain_q[2] = IV_C;
    chain_q[3] = IV_D;
    foreach (words_q[i]) words_q[i] = '0;
    nbytes_q = '0;
  endtask

  task automatic md5_compress();
    int shifts [16];
    logic [31:0] a, b, c, d, f, t;
    int rnd, k, wi, sh;
    shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    for (int s = 0; s < 64; s++) begin
      rnd = s / 16;
      k = s % 16;
      case (rnd)
        0: begin f = (b & c) | (~b & d); wi = k; end
        1: begin f = (b & d) | (c & ~d); wi = (5 * k + 1) % 16; end
        2: begin f = b ^ c ^ d; wi = (3 * k + 5) % 16; end
        default: begin f = c ^ (b | ~d); wi = (7 * k) % 16; end
      endcase
      sh = shifts[rnd * 4 + k % 4];
      t = a + f + words_q[wi] + rnd_const(s);
      t = (t << sh) | (t >> (32 - sh));
      a = d; d = c; c = b; b = b + t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    foreach (words_q[i]) words_q[i] = '0;
  endtask

  task automatic insert_byte(input int pos, input logic [7:0] v);
    words_q[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  task automatic predict_digest(input md5_in_t it);
    int pos;
    logic [63:0] bits;
    md5_out_t r;
    if (it.byte_valid) begin
      pos = int'(nbytes_q[5:0]);
      insert_byte(pos, it.data_byte);
      nbytes_q = nbytes_q + 61'd1;
      if (pos == 63) md5_compress();
    end
    if (it.last) begin
      pos = int'(nbytes_q[5:0]);
      insert_byte(pos, PAD_BYTE);
      if (pos > int'(LAST_FIT_POS)) md5_compress();
      bits = {nbytes_q, 3'b000};
      words_q[14] = bits[31:0];
      words_q[15] = bits[63:32];
      md5_compress();
      for (int i = 0; i < 4; i++) begin
        r.digest_word = chain_q[i];
        r.last_word = (i == 3);
        digest_q.push_back(r);
      end
      digest_init();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic queue_message(input int len, input bit noise);
    md5_in_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = 8'($urandom);
      it.byte_valid = 1'b1;
      it.last = 1'b0;
      if (noise && $urandom_range(0, 9) == 0) begin
        // ignored slot with junk data
        it.byte_valid = 1'b0;
        send_q.push_back(it);
        it.byte_valid = 1'b1;
      end
      if (i == len - 1 && $urandom_range(0, 1)) it.last = 1'b1;
      send_q.push_back(it);
    end
    if (len == 0 || !send_q[$].last) begin
      it.data_byte = 8'($urandom);
      it.byte_valid = 1'b0;
      it.last = 1'b1;
      send_q.push_back(it);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 21);
      if (!in_hold) begin
        if (send_q.size() > 0 && !drain_hold && (calm || $urandom_range(0, 99) >= 21)) begin
          in_valid <= 1'b1;
          in_data <= send_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_data <= '{data_byte: 8'($urandom), byte_valid: 1'b0, last: 1'b0};
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_cnt <= cycle_cnt + 1;
      in_hold <= in_valid && in_stall;
      if (in_valid && !in_stall) predict_digest(in_data);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data.digest_word));
        end else begin
          if (out_data.digest_word !== digest_q[0].digest_word)
            report_mismatch($sformatf("digest_word %h, want %h",
                                      out_data.digest_word, digest_q[0].digest_word));
          if (out_data.last_word !== digest_q[0].last_word)
            report_mismatch($sformatf("last_word %b, want %b",
                                      out_data.last_word, digest_q[0].last_word));
          void'(digest_q.pop_front());
        end
      end
      if (cycle_cnt > LIMIT_CYCLES) begin
        $display("timeout waiting for digest words");
        $display("md5_message_digest_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    md5_in_t it;
    int lens [3];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    err_cnt = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    drain_hold = 1'b0;
    in_hold = 1'b0;
    digest_init();
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: ignored item, empty message, extremes, byte with last
    send_q.push_back('{data_byte: 8'hff, byte_valid: 1'b0, last: 1'b0});
    send_q.push_back('{data_byte: 8'h00, byte_valid: 1'b0, last: 1'b1});
    send_q.push_back('{data_byte: 8'h00, byte_valid: 1'b1, last: 1'b1});
    send_q.push_back('{data_byte: 8'hff, byte_valid: 1'b1, last: 1'b0});
    send_q.push_back('{data_byte: 8'h55, byte_valid: 1'b0, last: 1'b0});
    send_q.push_back('{data_byte: 8'haa, byte_valid: 1'b1, last: 1'b0});
    send_q.push_back('{data_byte: 8'hff, byte_valid: 1'b0, last: 1'b1});
    // 56 bytes: pad spills into an extra block; 64 fills exactly
    lens = '{56, 64, 0};
    foreach (lens[i]) queue_message(lens[i], 1'b0);

    // hold off until all digests are out
    wait (send_q.size() == 0 && !in_valid);
    @(negedge clk) drain_hold = 1'b1;
    wait (digest_q.size() == 0);
    @(negedge clk) drain_hold = 1'b0;

    for (int m = 0; m < 6; m++) begin
      calm = (m >= 2 && m < 5);
      queue_message($urandom_range(0, 6), 1'b1);
      if ($urandom_range(0, 9) == 0) begin
        it = md5_in_t'(10'($urandom));
        it.last = 1'b0;
        send_q.push_back(it);
      end
      wait (send_q.size() < 4);
    end
    calm = 1'b0;
    wait (send_q.size() == 0 && !in_valid);
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("md5_message_digest_tb: clean");
    end else begin
      $display("md5_message_digest_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/md5_pkg.sv
rtl/md5_datapath.sv
rtl/md5_control.sv
rtl/md5_message_digest.sv
rtl/md5_checker.sv
dv/md5_message_digest_tb.sv
